// File: rtl/rpaf_pkg.sv
// Shared types and constants for the receive packet address filter.
// Item structs, configuration struct, register indexes and reset values.
// No dependencies.
package rpaf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [BYTE_W-1:0] HEADER_BYTES = 8'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_ADDRESS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMISCUOUS       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LENGTH  = 8'd3;

    localparam logic [BYTE_W-1:0] RST_NODE_ADDRESS      = 8'd1;
    localparam logic [BYTE_W-1:0] RST_BROADCAST_ADDRESS = 8'd255;
    localparam logic              RST_PROMISCUOUS       = 1'b0;
    localparam logic [BYTE_W-1:0] RST_MAX_FRAME_LENGTH  = 8'd64;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_start;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  payload_byte;
        logic [BYTE_W-1:0]  byte_index;
        logic               has_payload;
        logic               last;
        logic [BYTE_W-1:0]  dest_header;
        logic [BYTE_W-1:0]  source_header;
        logic [BYTE_W-1:0]  ident_header;
        logic [BYTE_W-1:0]  flag_header;
        logic [COUNT_W-1:0] good_frames;
    } t_out_item;

    typedef struct packed {
        logic [BYTE_W-1:0] node_address;
        logic [BYTE_W-1:0] broadcast_address;
        logic              promiscuous;
        logic [BYTE_W-1:0] max_frame_length;
    } t_cfg;

endpackage

// File: rtl/rpaf_frame_fsm.sv
// Frame phase tracker: length check, address filter, header capture, payload
// numbering and good-frame counting. Result is combinational from the item.
// Depends on rpaf_pkg.
module rpaf_frame_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpaf_pkg::t_cfg     i_cfg,
    input  logic               i_accept,
    input  rpaf_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output rpaf_pkg::t_out_item o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DEST,
        PH_SOURCE,
        PH_IDENT,
        PH_FLAGS,
        PH_PAYLOAD
    } t_phase;

    t_phase                            r_phase, n_phase;
    logic [rpaf_pkg::BYTE_W-1:0]       r_remaining, n_remaining;
    logic [rpaf_pkg::BYTE_W-1:0]       r_position, n_position;
    logic [rpaf_pkg::BYTE_W-1:0]       r_dest, n_dest;
    logic [rpaf_pkg::BYTE_W-1:0]       r_source, n_source;
    logic [rpaf_pkg::BYTE_W-1:0]       r_ident, n_ident;
    logic [rpaf_pkg::BYTE_W-1:0]       r_flag, n_flag;
    logic [rpaf_pkg::COUNT_W-1:0]      r_good, n_good;

    logic [rpaf_pkg::BYTE_W-1:0] w_b;
    logic                        w_last;
    logic [rpaf_pkg::BYTE_W-1:0] w_data;
    logic [rpaf_pkg::BYTE_W-1:0] w_index;
    logic                        w_has;

    always_comb begin
        w_b         = i_item.rx_byte;
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_position  = r_position;
        n_dest      = r_dest;
        n_source    = r_source;
        n_ident     = r_ident;
        n_flag      = r_flag;
        n_good      = r_good;
        o_res_valid = 1'b0;
        w_last      = 1'b0;
        w_data      = '0;
        w_index     = '0;
        w_has       = 1'b0;
        if (i_item.frame_start) begin
            if (w_b >= rpaf_pkg::HEADER_BYTES && w_b <= i_cfg.max_frame_length) begin
                n_remaining = w_b - rpaf_pkg::HEADER_BYTES;
                n_position  = '0;
                n_phase     = PH_DEST;
            end else begin
                n_phase = PH_IDLE;
            end
        end else begin
            case (r_phase)
                PH_DEST: begin
                    n_dest = w_b;
                    if (i_cfg.promiscuous || w_b == i_cfg.node_address ||
                        w_b == i_cfg.broadcast_address) begin
                        n_phase = PH_SOURCE;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_SOURCE: begin
                    n_source = w_b;
                    n_phase  = PH_IDENT;
                end
                PH_IDENT: begin
                    n_ident = w_b;
                    n_phase = PH_FLAGS;
                end
                PH_FLAGS: begin
                    n_flag     = w_b;
                    n_position = '0;
                    if (r_remaining == '0) begin
                        n_good      = r_good + 1'b1;
                        n_phase     = PH_IDLE;
                        o_res_valid = 1'b1;
                        w_last      = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    w_last      = (r_remaining <= 8'd1);
                    w_data      = w_b;
                    w_index     = r_position;
                    w_has       = 1'b1;
                    o_res_valid = 1'b1;
                    if (w_last) begin
                        n_good      = r_good + 1'b1;
                        n_remaining = '0;
                        n_phase     = PH_IDLE;
                    end else begin
                        n_remaining = r_remaining - 1'b1;
                    end
                    n_position = r_position + 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_res.payload_byte  = w_data;
        o_res.byte_index    = w_index;
        o_res.has_payload   = w_has;
        o_res.last          = w_last;
        o_res.dest_header   = n_dest;
        o_res.source_header = n_source;
        o_res.ident_header  = n_ident;
        o_res.flag_header   = n_flag;
        o_res.good_frames   = n_good;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_remaining <= '0;
            r_position  <= '0;
            r_dest      <= '0;
            r_source    <= '0;
            r_ident     <= '0;
            r_flag      <= '0;
            r_good      <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_position  <= n_position;
            r_dest      <= n_dest;
            r_source    <= n_source;
            r_ident     <= n_ident;
            r_flag      <= n_flag;
            r_good      <= n_good;
        end
    end

endmodule

// File: rtl/rx_packet_address_filter.sv
// Top level of the receive packet address filter: configuration registers,
// frame tracker and result register. Depends on rpaf_pkg and rpaf_frame_fsm.
//
// Takes one received byte per item and can accept an item in every cycle.
// A payload byte or the end of a header-only frame shows as a result in the
// cycle after its item is accepted; length bytes, headers, trailing bytes and
// bytes of dropped frames give no result. The single result register sets the
// rate: while it holds a result that is stalled, input is stalled too. No
// clearing pass after reset. Configuration writes are always ready and take
// effect on the next item; write them while no frame is in flight.
module rx_packet_address_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  rpaf_pkg::t_in_item            i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output rpaf_pkg::t_out_item           o_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rpaf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpaf_pkg::BYTE_W-1:0]    i_cfg_data
);

    rpaf_pkg::t_cfg      r_cfg;
    rpaf_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic                w_in_accept;
    logic                w_res_valid;
    rpaf_pkg::t_out_item w_res;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid && i_stall;
    assign w_in_accept = i_valid && !o_stall;
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_address      <= rpaf_pkg::RST_NODE_ADDRESS;
            r_cfg.broadcast_address <= rpaf_pkg::RST_BROADCAST_ADDRESS;
            r_cfg.promiscuous       <= rpaf_pkg::RST_PROMISCUOUS;
            r_cfg.max_frame_length  <= rpaf_pkg::RST_MAX_FRAME_LENGTH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rpaf_pkg::CFG_NODE_ADDRESS:      r_cfg.node_address      <= i_cfg_data;
                rpaf_pkg::CFG_BROADCAST_ADDRESS: r_cfg.broadcast_address <= i_cfg_data;
                rpaf_pkg::CFG_PROMISCUOUS:       r_cfg.promiscuous       <= i_cfg_data[0];
                rpaf_pkg::CFG_MAX_FRAME_LENGTH:  r_cfg.max_frame_length  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rpaf_frame_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (w_in_accept),
        .i_item      (i_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= w_res_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_res_valid) begin
            r_out <= w_res;
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty result register");

    a_header_only_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.has_payload) |->
            (o_item.last && o_item.byte_index == '0 && o_item.payload_byte == '0))
        else $error("header-only result malformed");

    a_start_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_item.frame_start && (!o_valid || !i_stall)) |=> !o_valid)
        else $error("length byte produced a result");
`endif

endmodule
